### hw/rtl/kmat_pkg.sv
// Shared types, codes and translation tables for the key matrix to ASCII translator.
// Used by kmat_key_xlate and key_matrix_to_ascii_translator_unit; depends on nothing.
package kmat_pkg;

  localparam int HALF_W    = 35;
  localparam int FRAME_W   = 2 * HALF_W;
  localparam int CODE_W    = 7;
  localparam int MAX_BYTES = 28;
  localparam int CNT_W     = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Register byte addresses.
  localparam logic [APB_AW-1:0] ADDR_BREAK_EN = 3'd0;

  // Special scan codes.
  localparam logic [CODE_W-1:0] CODE_NUL0   = 7'd0;
  localparam logic [CODE_W-1:0] CODE_NUL1   = 7'd1;
  localparam logic [CODE_W-1:0] CODE_SCROLL = 7'd3;
  localparam logic [CODE_W-1:0] CODE_CAPS   = 7'd12;
  localparam logic [CODE_W-1:0] CODE_BREAK  = 7'd67;
  localparam logic [CODE_W-1:0] CODE_LEFT   = 7'd35;
  localparam logic [CODE_W-1:0] CODE_DOWN   = 7'd45;
  localparam logic [CODE_W-1:0] CODE_UP     = 7'd55;
  localparam logic [CODE_W-1:0] CODE_RIGHT  = 7'd65;
  localparam logic [CODE_W-1:0] CODE_SHIFT_L = 7'd13;
  localparam logic [CODE_W-1:0] CODE_SHIFT_R = 7'd49;
  localparam logic [CODE_W-1:0] CODE_CTRL    = 7'd22;
  localparam logic [CODE_W-1:0] CODE_MOD_A   = 7'd4;
  localparam logic [CODE_W-1:0] CODE_MOD_B   = 7'd14;
  localparam logic [CODE_W-1:0] CODE_MOD_C   = 7'd24;
  localparam logic [CODE_W-1:0] CODE_MOD_D   = 7'd34;

  // Output byte constants.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CSI = 8'h5B;
  localparam logic [7:0] CH_UP  = 8'h41;
  localparam logic [7:0] CH_DN  = 8'h42;
  localparam logic [7:0] CH_RT  = 8'h43;
  localparam logic [7:0] CH_LT  = 8'h44;

  // Action kinds from the key translation unit.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_BYTE   = 3'd1;
  localparam logic [2:0] ACT_ARROW  = 3'd2;
  localparam logic [2:0] ACT_CAPS   = 3'd3;
  localparam logic [2:0] ACT_SCROLL = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
  } kmat_act_t;

  typedef struct packed {
    logic [HALF_W-1:0] pressed_high;
    logic [HALF_W-1:0] pressed_low;
  } kmat_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       caps_state;
    logic       scroll_state;
  } kmat_out_t;

  localparam logic [7:0] PLAIN_TAB [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h37,8'h75,8'h67,8'h6A,8'h2C,
    8'h31,8'h71,8'h00,8'h00,8'h00, 8'h38,8'h69,8'h68,8'h6B,8'h00,
    8'h32,8'h77,8'h00,8'h7A,8'h00, 8'h39,8'h30,8'h6F,8'h6C,8'h2E,
    8'h33,8'h65,8'h61,8'h78,8'h00, 8'h00,8'h2D,8'h70,8'h3B,8'h2F,
    8'h34,8'h72,8'h73,8'h63,8'h20, 8'h00,8'h3D,8'h5B,8'h27,8'h00,
    8'h35,8'h74,8'h64,8'h76,8'h6E, 8'h00,8'h27,8'h5D,8'h0D,8'h5C,
    8'h36,8'h79,8'h66,8'h62,8'h6D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] SHIFT_TAB [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h26,8'h55,8'h47,8'h4A,8'h3C,
    8'h21,8'h51,8'h00,8'h00,8'h00, 8'h2A,8'h49,8'h48,8'h4B,8'h00,
    8'h40,8'h57,8'h00,8'h5A,8'h00, 8'h28,8'h29,8'h4F,8'h4C,8'h3E,
    8'h23,8'h45,8'h41,8'h58,8'h00, 8'h00,8'h5F,8'h50,8'h3A,8'h3F,
    8'h24,8'h52,8'h53,8'h43,8'h20, 8'h00,8'h2B,8'h7B,8'h22,8'h00,
    8'h25,8'h54,8'h44,8'h56,8'h4E, 8'h00,8'h7E,8'h7D,8'h0D,8'h7C,
    8'h5E,8'h59,8'h46,8'h42,8'h4D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] CAPS_TAB [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h37,8'h55,8'h47,8'h4A,8'h2C,
    8'h31,8'h51,8'h00,8'h00,8'h00, 8'h38,8'h49,8'h48,8'h4B,8'h00,
    8'h32,8'h57,8'h00,8'h5A,8'h00, 8'h39,8'h30,8'h4F,8'h4C,8'h2E,
    8'h33,8'h45,8'h41,8'h58,8'h00, 8'h00,8'h2D,8'h50,8'h3B,8'h2F,
    8'h34,8'h52,8'h53,8'h43,8'h20, 8'h00,8'h3D,8'h5B,8'h27,8'h00,
    8'h35,8'h54,8'h44,8'h56,8'h4E, 8'h00,8'h27,8'h5D,8'h0D,8'h5C,
    8'h36,8'h59,8'h46,8'h42,8'h4D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] CTRL_TAB [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h00,8'h15,8'h07,8'h0A,8'h00,
    8'h00,8'h11,8'h00,8'h00,8'h00, 8'h00,8'h09,8'h08,8'h0B,8'h00,
    8'h00,8'h17,8'h00,8'h1A,8'h00, 8'h00,8'h00,8'h0F,8'h0A,8'h00,
    8'h00,8'h05,8'h01,8'h18,8'h00, 8'h00,8'h00,8'h10,8'h00,8'h1F,
    8'h00,8'h12,8'h13,8'h03,8'h00, 8'h00,8'h00,8'h1B,8'h00,8'h00,
    8'h00,8'h14,8'h04,8'h16,8'h0E, 8'h00,8'h1E,8'h1D,8'h00,8'h1C,
    8'h00,8'h19,8'h06,8'h02,8'h0D, 8'h00,8'h08,8'h00,8'h00,8'h0A };

endpackage

### hw/rtl/kmat_key_xlate.sv
// Key translation unit: classifies one new scan code and looks up its byte.
// Shared by every key of a frame under the sequencer; depends on kmat_pkg.
module kmat_key_xlate
  import kmat_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  logic              ctrl_held,
  input  logic              shift_held,
  input  logic              caps_on,
  input  logic              break_en,
  output kmat_act_t         act
);

  logic is_mod;

  assign is_mod = (code == CODE_MOD_A) || (code == CODE_SHIFT_L) || (code == CODE_MOD_B) ||
                  (code == CODE_CTRL) || (code == CODE_MOD_C) || (code == CODE_MOD_D) ||
                  (code == CODE_SHIFT_R);

  always_comb begin
    act.kind = ACT_NONE;
    act.ch   = CH_NUL;
    priority if (code == CODE_NUL0 || code == CODE_NUL1) begin
      act.kind = ACT_NONE;
    end else if (code == CODE_BREAK) begin
      act.kind = break_en ? ACT_BYTE : ACT_NONE;
    end else if (code == CODE_CAPS) begin
      act.kind = ACT_CAPS;
    end else if (code == CODE_SCROLL) begin
      act.kind = ACT_SCROLL;
    end else if (code == CODE_LEFT) begin
      act.kind = ACT_ARROW;
      act.ch   = CH_LT;
    end else if (code == CODE_DOWN) begin
      act.kind = ACT_ARROW;
      act.ch   = CH_DN;
    end else if (code == CODE_UP) begin
      act.kind = ACT_ARROW;
      act.ch   = CH_UP;
    end else if (code == CODE_RIGHT) begin
      act.kind = ACT_ARROW;
      act.ch   = CH_RT;
    end else if (is_mod) begin
      act.kind = ACT_NONE;
    end else if (ctrl_held) begin
      act.kind = ACT_BYTE;
      act.ch   = CTRL_TAB[code];
    end else if (caps_on) begin
      act.kind = ACT_BYTE;
      act.ch   = CAPS_TAB[code];
    end else if (shift_held) begin
      act.kind = ACT_BYTE;
      act.ch   = SHIFT_TAB[code];
    end else begin
      act.kind = ACT_BYTE;
      act.ch   = PLAIN_TAB[code];
    end
  end

endmodule

### hw/rtl/key_matrix_to_ascii_translator_unit.sv
// Top level of the key matrix to ASCII translator: frame capture, key walk
// sequencer, byte buffer, output register and APB register. Uses kmat_pkg, kmat_key_xlate.
//
// Usage: each input transaction on in_valid/in_ready carries one scan frame, a
// pressed bitmap in two 35-bit halves. The block walks the scan codes one per
// cycle, pausing for arrow keys, through a single translation unit, marks new
// keys down, and collects the bytes they cause in a 28-entry buffer. An arrow
// key holds the walk in ST_ARROW1 and ST_ARROW2 for the rest of its escape
// sequence. After the walk the bytes leave on out_valid/out_ready, one per
// output transaction, the last one flagged, each carrying the lock states after
// the whole frame. The walk covers codes 0 to KEY_COUNT - 1 and ends early at
// the first new key beyond NEW_KEY_LIMIT. The drain moves one byte per cycle
// while the receiver does not stall. in_ready is high only while the sequencer
// is idle, so a new frame is taken only after the buffer has drained. A
// stalled receiver holds the drain; the byte in the output register stays
// until taken. Reset clears the key-down set, both lock states, the break
// enable and all control state. break_enable sits at APB byte address 0.
module key_matrix_to_ascii_translator_unit
  import kmat_pkg::*;
#(
  parameter int KEY_COUNT     = 70,
  parameter int NEW_KEY_LIMIT = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kmat_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kmat_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int KIDX_W    = $clog2(KEY_COUNT);
  localparam int HANDLED_W = $clog2(NEW_KEY_LIMIT + 1);
  localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(KEY_COUNT - 1);
  localparam logic [FRAME_W-1:0] KEY_MASK =
    FRAME_W'((71'(1) << KEY_COUNT) - 71'(1));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_ARROW1 = 3'd2;
  localparam logic [2:0] ST_ARROW2 = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]           state;
  logic [FRAME_W-1:0]   frame;
  logic [FRAME_W-1:0]   in_bits;
  logic [KEY_COUNT-1:0] key_down;
  logic [CODE_W-1:0]    code;
  logic [HANDLED_W-1:0] handled;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rd_idx;
  logic [7:0]           byte_buf [MAX_BYTES];
  logic [7:0]           arrow_ch;
  logic                 walk_end;
  logic                 caps_lock_on;
  logic                 scroll_lock_on;
  logic                 break_enable;

  logic      in_fire;
  logic      is_new;
  logic      at_limit;
  logic      out_load;
  kmat_act_t act;

  assign in_bits  = {in_data.pressed_high, in_data.pressed_low} & KEY_MASK;
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_new   = frame[code] && !key_down[code[KIDX_W-1:0]];
  assign at_limit = (handled == HANDLED_W'(NEW_KEY_LIMIT));
  assign out_load = (state == ST_EMIT) && (rd_idx != count) && (!out_valid || out_ready);

  kmat_key_xlate u_xlate (
    .code       (code),
    .ctrl_held  (frame[CODE_CTRL]),
    .shift_held (frame[CODE_SHIFT_L] || frame[CODE_SHIFT_R]),
    .caps_on    (caps_lock_on),
    .break_en   (break_enable),
    .act        (act)
  );

  // Configuration register.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_BREAK_EN) begin
      prdata[0] = break_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_BREAK_EN) begin
      break_enable <= pwdata[0];
    end
  end

  // Sequencer: capture, walk codes, finish arrow sequences, then drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      key_down       <= '0;
      caps_lock_on   <= 1'b0;
      scroll_lock_on <= 1'b0;
      code           <= '0;
      handled        <= '0;
      count          <= '0;
      rd_idx         <= '0;
      walk_end       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            key_down <= key_down & in_bits[KEY_COUNT-1:0];
            code     <= '0;
            handled  <= '0;
            count    <= '0;
            rd_idx   <= '0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          code     <= code + 1'b1;
          walk_end <= (code == LAST_CODE);
          if (is_new && at_limit) begin
            state <= ST_EMIT;
          end else begin
            if (is_new) begin
              handled                      <= handled + 1'b1;
              key_down[code[KIDX_W-1:0]]   <= 1'b1;
              if (act.kind == ACT_BYTE || act.kind == ACT_ARROW) begin
                count <= count + 1'b1;
              end
              if (act.kind == ACT_CAPS) begin
                caps_lock_on <= !caps_lock_on;
              end
              if (act.kind == ACT_SCROLL) begin
                scroll_lock_on <= !scroll_lock_on;
              end
            end
            if (is_new && act.kind == ACT_ARROW) begin
              state <= ST_ARROW1;
            end else if (code == LAST_CODE) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_ARROW1: begin
          count <= count + 1'b1;
          state <= ST_ARROW2;
        end
        ST_ARROW2: begin
          count <= count + 1'b1;
          state <= walk_end ? ST_EMIT : ST_WALK;
        end
        ST_EMIT: begin
          if (rd_idx == count) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Byte buffer writes: one byte per cycle at the fill position.
  always_ff @(posedge clk) begin
    if (state == ST_WALK && is_new && !at_limit) begin
      if (act.kind == ACT_BYTE) begin
        byte_buf[count] <= act.ch;
      end else if (act.kind == ACT_ARROW) begin
        byte_buf[count] <= CH_ESC;
        arrow_ch        <= act.ch;
      end
    end else if (state == ST_ARROW1) begin
      byte_buf[count] <= CH_CSI;
    end else if (state == ST_ARROW2) begin
      byte_buf[count] <= arrow_ch;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_byte      <= byte_buf[rd_idx];
      out_data.last_of_frame <= (CNT_W'(rd_idx + 1'b1) == count);
      out_data.caps_state    <= caps_lock_on;
      out_data.scroll_state  <= scroll_lock_on;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame <= in_bits;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BYTES))
    else $error("byte buffer fill exceeds its depth");

  a_handled_bound: assert property (@(posedge clk) disable iff (rst)
    handled <= HANDLED_W'(NEW_KEY_LIMIT))
    else $error("more new keys handled than the frame limit");

  a_down_subset: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (key_down & ~frame[KEY_COUNT-1:0]) == '0)
    else $error("key marked down that is not pressed in the current frame");

  a_no_drain_outside_emit: assert property (@(posedge clk) disable iff (rst)
    state != ST_EMIT |=> !$rose(out_valid))
    else $error("output loaded outside the drain phase");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_WALK && code == '0 && count == '0)
    else $error("accepted frame did not start a fresh walk");

endmodule

### tb/sv/key_matrix_to_ascii_translator_unit_tb.sv
// Self-checking testbench for key_matrix_to_ascii_translator_unit.
// Depends on kmat_pkg for the port types, scan codes and byte constants.
// Scan frames go in on one valid/ready channel, and each output byte is checked against a local model.
`timescale 1ns / 100ps

module key_matrix_to_ascii_translator_unit_tb;
  import kmat_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam int LONG_HOLD    = 600;
  localparam int KEY_LIMIT    = 20;

  // Ordinary keys used by the directed frames.
  localparam int KEY_Q       = 11;
  localparam int KEY_BLANK   = 19;
  localparam int KEY_Z       = 23;
  localparam int KEY_A       = 32;
  localparam int KEY_NEWLINE = 69;

  // Sixteen keys that each give one nonzero byte and are not special.
  localparam int BYTE_KEYS [16] = '{5, 6, 7, 8, 9, 10, 11, 15, 16, 17, 18, 20, 21, 23, 25, 26};
  localparam int SPECIAL_KEYS [10] = '{CODE_SHIFT_L, CODE_SHIFT_R, CODE_CTRL, CODE_CAPS,
    CODE_SCROLL, CODE_LEFT, CODE_DOWN, CODE_UP, CODE_RIGHT, CODE_BREAK};

  localparam logic [7:0] LOWER_MAP [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h37,8'h75,8'h67,8'h6A,8'h2C,
    8'h31,8'h71,8'h00,8'h00,8'h00, 8'h38,8'h69,8'h68,8'h6B,8'h00,
    8'h32,8'h77,8'h00,8'h7A,8'h00, 8'h39,8'h30,8'h6F,8'h6C,8'h2E,
    8'h33,8'h65,8'h61,8'h78,8'h00, 8'h00,8'h2D,8'h70,8'h3B,8'h2F,
    8'h34,8'h72,8'h73,8'h63,8'h20, 8'h00,8'h3D,8'h5B,8'h27,8'h00,
    8'h35,8'h74,8'h64,8'h76,8'h6E, 8'h00,8'h27,8'h5D,8'h0D,8'h5C,
    8'h36,8'h79,8'h66,8'h62,8'h6D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] SHIFTED_MAP [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h26,8'h55,8'h47,8'h4A,8'h3C,
    8'h21,8'h51,8'h00,8'h00,8'h00, 8'h2A,8'h49,8'h48,8'h4B,8'h00,
    8'h40,8'h57,8'h00,8'h5A,8'h00, 8'h28,8'h29,8'h4F,8'h4C,8'h3E,
    8'h23,8'h45,8'h41,8'h58,8'h00, 8'h00,8'h5F,8'h50,8'h3A,8'h3F,
    8'h24,8'h52,8'h53,8'h43,8'h20, 8'h00,8'h2B,8'h7B,8'h22,8'h00,
    8'h25,8'h54,8'h44,8'h56,8'h4E, 8'h00,8'h7E,8'h7D,8'h0D,8'h7C,
    8'h5E,8'h59,8'h46,8'h42,8'h4D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] CAPS_MAP [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h37,8'h55,8'h47,8'h4A,8'h2C,
    8'h31,8'h51,8'h00,8'h00,8'h00, 8'h38,8'h49,8'h48,8'h4B,8'h00,
    8'h32,8'h57,8'h00,8'h5A,8'h00, 8'h39,8'h30,8'h4F,8'h4C,8'h2E,
    8'h33,8'h45,8'h41,8'h58,8'h00, 8'h00,8'h2D,8'h50,8'h3B,8'h2F,
    8'h34,8'h52,8'h53,8'h43,8'h20, 8'h00,8'h3D,8'h5B,8'h27,8'h00,
    8'h35,8'h54,8'h44,8'h56,8'h4E, 8'h00,8'h27,8'h5D,8'h0D,8'h5C,
    8'h36,8'h59,8'h46,8'h42,8'h4D, 8'h00,8'h08,8'h00,8'h7F,8'h0A };

  localparam logic [7:0] CONTROL_MAP [FRAME_W] = '{
    8'h1B,8'h00,8'h09,8'h00,8'h00, 8'h00,8'h15,8'h07,8'h0A,8'h00,
    8'h00,8'h11,8'h00,8'h00,8'h00, 8'h00,8'h09,8'h08,8'h0B,8'h00,
    8'h00,8'h17,8'h00,8'h1A,8'h00, 8'h00,8'h00,8'h0F,8'h0A,8'h00,
    8'h00,8'h05,8'h01,8'h18,8'h00, 8'h00,8'h00,8'h10,8'h00,8'h1F,
    8'h00,8'h12,8'h13,8'h03,8'h00, 8'h00,8'h00,8'h1B,8'h00,8'h00,
    8'h00,8'h14,8'h04,8'h16,8'h0E, 8'h00,8'h1E,8'h1D,8'h00,8'h1C,
    8'h00,8'h19,8'h06,8'h02,8'h0D, 8'h00,8'h08,8'h00,8'h00,8'h0A };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  kmat_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  kmat_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Model state and the bytes still owed by the block.
  logic [FRAME_W-1:0] keys_down = '0;
  logic               caps_on   = 1'b0;
  logic               scroll_on = 1'b0;
  logic               break_en  = 1'b0;
  kmat_out_t          expected_bytes [$];

  int error_count = 0;
  int cycle_count = 0;
  int tx_gap_max  = 14;
  int rx_gap_max  = 14;
  int rx_hold     = 0;

  always #1 clk = ~clk;

  key_matrix_to_ascii_translator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    error_count++;
    $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic [FRAME_W-1:0] one_key(input int code);
    return {{(FRAME_W-1){1'b0}}, 1'b1} << code;
  endfunction

  // All four arrows plus sixteen byte keys: twenty new keys and 28 bytes.
  function automatic logic [FRAME_W-1:0] burst_keys();
    logic [FRAME_W-1:0] mask;
    mask = one_key(CODE_LEFT) | one_key(CODE_DOWN) | one_key(CODE_UP) | one_key(CODE_RIGHT);
    foreach (BYTE_KEYS[i]) mask |= one_key(BYTE_KEYS[i]);
    return mask;
  endfunction

  function automatic logic is_silent_key(input int code);
    return code == CODE_NUL0 || code == CODE_NUL1 || code == CODE_MOD_A ||
           code == CODE_SHIFT_L || code == CODE_MOD_B || code == CODE_CTRL ||
           code == CODE_MOD_C || code == CODE_MOD_D || code == CODE_SHIFT_R;
  endfunction

  function automatic logic [7:0] arrow_final_byte(input int code);
    if (code == CODE_LEFT) return CH_LT;
    if (code == CODE_DOWN) return CH_DN;
    if (code == CODE_UP) return CH_UP;
    return CH_RT;
  endfunction

  // Walks one scan frame and queues the bytes it should produce.
  function automatic void translate_frame(input logic [FRAME_W-1:0] pressed);
    logic [7:0] frame_bytes [$];
    logic       shift_held;
    logic       ctrl_held;
    int         handled;
    kmat_out_t  item;
    handled    = 0;
    keys_down  = keys_down & pressed;
    shift_held = pressed[CODE_SHIFT_L] | pressed[CODE_SHIFT_R];
    ctrl_held  = pressed[CODE_CTRL];
    for (int code = 0; code < FRAME_W; code++) begin
      if (pressed[code] && !keys_down[code]) begin
        // Keys past the limit stay out of the set and count as new next frame.
        if (handled == KEY_LIMIT) break;
        handled++;
        keys_down[code] = 1'b1;
        if (code == CODE_BREAK) begin
          if (break_en) frame_bytes.push_back(CH_NUL);
        end else if (code == CODE_CAPS) begin
          caps_on = !caps_on;
        end else if (code == CODE_SCROLL) begin
          scroll_on = !scroll_on;
        end else if (code == CODE_LEFT || code == CODE_DOWN || code == CODE_UP ||
                     code == CODE_RIGHT) begin
          frame_bytes.push_back(CH_ESC);
          frame_bytes.push_back(CH_CSI);
          frame_bytes.push_back(arrow_final_byte(code));
        end else if (!is_silent_key(code)) begin
          if (ctrl_held) frame_bytes.push_back(CONTROL_MAP[code]);
          else if (caps_on) frame_bytes.push_back(CAPS_MAP[code]);
          else if (shift_held) frame_bytes.push_back(SHIFTED_MAP[code]);
          else frame_bytes.push_back(LOWER_MAP[code]);
        end
      end
    end
    // Every byte carries the lock states as they stand after the whole frame.
    foreach (frame_bytes[i]) begin
      item.out_byte      = frame_bytes[i];
      item.last_of_frame = (i == frame_bytes.size() - 1);
      item.caps_state    = caps_on;
      item.scroll_state  = scroll_on;
      expected_bytes.push_back(item);
    end
  endfunction

  task automatic send_frame(input logic [FRAME_W-1:0] pressed);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.pressed_low  = pressed[HALF_W-1:0];
    in_data.pressed_high = pressed[FRAME_W-1:HALF_W];
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    translate_frame(pressed);
  endtask

  // Frames that produce no bytes can still be in the key walk, so wait out its latency too.
  task automatic let_block_settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = ADDR_BREAK_EN;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_break_enable(input logic value);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, APB_DW'(value), rd);
    break_en = value;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DW'(value))
      report($sformatf("break_enable reads 0x%0h, expected %0d", rd, value));
  endtask

  task automatic test_break_key();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== '0) report($sformatf("break_enable reads 0x%0h after reset", rd));
    program_break_enable(1'b1);
    send_frame(one_key(CODE_BREAK));
    send_frame('0);
    let_block_settle();
    program_break_enable(1'b0);
    send_frame(one_key(CODE_BREAK));
    send_frame('0);
    let_block_settle();
  endtask

  task automatic test_key_classes();
    send_frame('0);
    send_frame(one_key(KEY_A));
    send_frame('0);
    send_frame(one_key(CODE_SHIFT_L) | one_key(KEY_A));
    send_frame(one_key(CODE_SHIFT_R) | one_key(KEY_Q));
    send_frame(one_key(CODE_CTRL) | one_key(KEY_Z));
    // Codes 0 and 1 are silent, but a plain key with a zero entry still sends it.
    send_frame(one_key(CODE_NUL0) | one_key(CODE_NUL1) | one_key(KEY_BLANK));
    send_frame(one_key(CODE_SCROLL));
    send_frame('0);
    // Q comes before caps lock in the walk, A after it, so only A sees caps on.
    send_frame(one_key(KEY_Q) | one_key(CODE_CAPS) | one_key(KEY_A));
    send_frame(one_key(CODE_CTRL) | one_key(KEY_Z));
    send_frame(one_key(CODE_SHIFT_L) | one_key(KEY_Q));
    send_frame(one_key(CODE_CAPS));
    send_frame(one_key(CODE_LEFT) | one_key(CODE_DOWN) | one_key(CODE_UP) | one_key(CODE_RIGHT));
    send_frame('0);
    send_frame(one_key(CODE_MOD_A) | one_key(CODE_SHIFT_L) | one_key(CODE_MOD_B) |
               one_key(CODE_CTRL) | one_key(CODE_MOD_C) | one_key(CODE_MOD_D) |
               one_key(CODE_SHIFT_R));
    send_frame(burst_keys());
    send_frame('0);
    // Every key held at once takes four frames to get through the new-key limit.
    repeat (4) send_frame({FRAME_W{1'b1}});
    send_frame('0);
    send_frame(one_key(KEY_NEWLINE));
    send_frame('0);
  endtask

  task automatic test_random_typing();
    logic [FRAME_W-1:0] held;
    logic [FRAME_W-1:0] fresh;
    int                 pick;
    held = '0;
    for (int phase = 0; phase < 3; phase++) begin
      let_block_settle();
      program_break_enable(phase != 1);
      tx_gap_max = (phase == 1) ? 0 : 14;
      rx_gap_max = (phase == 1) ? 0 : 14;
      for (int n = 0; n < 27; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // Typing: release some held keys and press a few new ones.
          for (int b = 0; b < FRAME_W; b++)
            if ($urandom_range(0, 9) < 3) held[b] = 1'b0;
          repeat ($urandom_range(1, 4)) held[$urandom_range(0, FRAME_W - 1)] = 1'b1;
          if ($urandom_range(0, 3) == 0) held[SPECIAL_KEYS[$urandom_range(0, 9)]] = 1'b1;
          fresh = held;
        end else if (pick == 7) begin
          fresh = '0;
        end else begin
          for (int b = 0; b < FRAME_W; b++) fresh[b] = $urandom_range(0, 1);
        end
        send_frame(fresh);
        held = fresh;
      end
    end
    tx_gap_max = 14;
    rx_gap_max = 14;
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 3;
    rx_hold    = LONG_HOLD;
    repeat (6) begin
      send_frame(burst_keys());
      send_frame('0);
    end
    tx_gap_max = 14;
    rx_gap_max = 14;
  endtask

  // Output side: random stalls, one transaction per byte, each checked in order.
  initial begin : byte_sink
    int        stall;
    kmat_out_t want;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte 0x%02h", out_data.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report($sformatf("out_byte 0x%02h, expected 0x%02h", out_data.out_byte,
                           want.out_byte));
        if (out_data.last_of_frame !== want.last_of_frame)
          report($sformatf("last_of_frame %b, expected %b", out_data.last_of_frame,
                           want.last_of_frame));
        if (out_data.caps_state !== want.caps_state)
          report($sformatf("caps_state %b, expected %b", out_data.caps_state,
                           want.caps_state));
        if (out_data.scroll_state !== want.scroll_state)
          report($sformatf("scroll_state %b, expected %b", out_data.scroll_state,
                           want.scroll_state));
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_break_key();
    test_key_classes();
    test_random_typing();
    let_block_settle();
    test_backpressure();
    let_block_settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/kmat_pkg.sv
hw/rtl/kmat_key_xlate.sv
hw/rtl/key_matrix_to_ascii_translator_unit.sv
tb/sv/key_matrix_to_ascii_translator_unit_tb.sv
